FILE: hdl/tche_pkg.sv
// package: phases, kinds, status codes and result type for the client hello extractor
`timescale 1ns / 1ps
package tche_pkg;
  localparam int ETH_HEADER_BYTES = 14;
  localparam int HELLO_VERSION_OFFSET = 9;
  localparam int SESSION_LENGTH_OFFSET = 43;
  localparam int MAX_VLAN_TAGS = 2;
  localparam int MAX_FRAME_BYTES = 65535;

  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_IPV6 = 16'h86dd;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] REC_HANDSHAKE = 8'd22;
  localparam logic [15:0] EXT_CURVES = 16'h000a;
  localparam logic [15:0] EXT_POINT_FMT = 16'h000b;
  localparam logic [15:0] EXT_SIG_ALG = 16'h000d;
  localparam logic [15:0] HELLO_MIN = 16'h0300;
  localparam logic [15:0] HELLO_MAX = 16'h0303;

  typedef enum logic [4:0] {
    PH_ETH, PH_IP4, PH_IP6, PH_TCP, PH_TLS, PH_CIPH, PH_COMP_LEN, PH_COMP,
    PH_XLEN_HI, PH_XLEN_LO, PH_XTYPE_HI, PH_XTYPE_LO, PH_XBODYLEN_HI,
    PH_XBODYLEN_LO, PH_XBODY, PH_DONE, PH_STOP
  } phase_t;

  typedef enum logic [3:0] {
    K_REC, K_HELLO, K_CIPHER, K_COMP, K_EXT, K_CURVE, K_SIG, K_POINT, K_SUMMARY
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK, ST_ETHERTYPE, ST_VLAN, ST_IP_HL, ST_NOT_TCP, ST_V6_VER, ST_NOT_HELLO,
    ST_TCP_HL, ST_TLS_VER, ST_SESSION, ST_TRUNC
  } status_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [15:0] value;
    logic [3:0] status;
    logic final_res;
  } result_t;

  typedef struct packed {
    logic elem_valid;
    result_t elem;
    logic sum_valid;
    result_t sum;
  } step_t;
endpackage

FILE: hdl/tche_parser.sv
// parser: state registers and per-byte next-state logic
`timescale 1ns / 1ps
module tche_parser #(
  parameter int MAX_VLAN_TAGS = tche_pkg::MAX_VLAN_TAGS,
  parameter int MAX_FRAME_BYTES = tche_pkg::MAX_FRAME_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [7:0] in_byte,
  input  logic in_last,
  output tche_pkg::step_t step
);
  logic [15:0] byte_position, byte_position_next;
  tche_pkg::phase_t parse_phase, parse_phase_next;
  logic [2:0] vlan_tag_count, vlan_tag_count_next;
  logic [15:0] section_start, section_start_next;
  logic [7:0] header_length, header_length_next;
  logic [1:0] ip_version_seen, ip_version_seen_next;
  logic [15:0] section_remaining, section_remaining_next;
  logic [15:0] extensions_remaining, extensions_remaining_next;
  logic [15:0] current_ext_type, current_ext_type_next;
  logic [15:0] byte_accumulator, byte_accumulator_next;
  logic [7:0] session_id_length, session_id_length_next;
  logic [3:0] frame_status, frame_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      parse_phase <= tche_pkg::PH_ETH;
      vlan_tag_count <= '0;
      section_start <= '0;
      header_length <= '0;
      ip_version_seen <= '0;
      section_remaining <= '0;
      extensions_remaining <= '0;
      current_ext_type <= '0;
      byte_accumulator <= '0;
      session_id_length <= '0;
      frame_status <= '0;
    end else if (in_valid) begin
      byte_position <= byte_position_next;
      parse_phase <= parse_phase_next;
      vlan_tag_count <= vlan_tag_count_next;
      section_start <= section_start_next;
      header_length <= header_length_next;
      ip_version_seen <= ip_version_seen_next;
      section_remaining <= section_remaining_next;
      extensions_remaining <= extensions_remaining_next;
      current_ext_type <= current_ext_type_next;
      byte_accumulator <= byte_accumulator_next;
      session_id_length <= session_id_length_next;
      frame_status <= frame_status_next;
    end
  end

  logic [15:0] off, ext_word, cs_hi, sec_dec, acc_dec, pos_inc, after_ph_off;
  logic v6, list_end, body_end;
  logic [3:0] st;

  always_comb begin
    byte_position_next = byte_position;
    parse_phase_next = parse_phase;
    vlan_tag_count_next = vlan_tag_count;
    section_start_next = section_start;
    header_length_next = header_length;
    ip_version_seen_next = ip_version_seen;
    section_remaining_next = section_remaining;
    extensions_remaining_next = extensions_remaining;
    current_ext_type_next = current_ext_type;
    byte_accumulator_next = byte_accumulator;
    session_id_length_next = session_id_length;
    frame_status_next = frame_status;
    step = '0;
    st = tche_pkg::ST_TRUNC;
    off = byte_position - section_start;
    pos_inc = byte_position + 16'd1;
    ext_word = byte_accumulator | {8'd0, in_byte};
    cs_hi = 16'(tche_pkg::SESSION_LENGTH_OFFSET + 1) + {8'd0, session_id_length};
    sec_dec = section_remaining - 16'd1;
    acc_dec = byte_accumulator - 16'd1;
    v6 = (ip_version_seen == 2'd2);
    list_end = (extensions_remaining == 16'd1);
    body_end = 1'b0;
    if (32'(byte_position) < MAX_FRAME_BYTES) begin
      byte_position_next = pos_inc;
      case (parse_phase)
        tche_pkg::PH_ETH: begin
          if (off == 16'(tche_pkg::ETH_HEADER_BYTES - 2)) begin
            byte_accumulator_next = {in_byte, 8'd0};
          end else if (off == 16'(tche_pkg::ETH_HEADER_BYTES - 1)) begin
            if (ext_word == tche_pkg::TYPE_VLAN) begin
              if (32'(vlan_tag_count) >= MAX_VLAN_TAGS) begin
                frame_status_next = tche_pkg::ST_VLAN;
                parse_phase_next = tche_pkg::PH_STOP;
              end else begin
                vlan_tag_count_next = vlan_tag_count + 3'd1;
                section_start_next = pos_inc - 16'(tche_pkg::ETH_HEADER_BYTES - 4);
              end
            end else if (ext_word == tche_pkg::TYPE_IPV4) begin
              ip_version_seen_next = 2'd1;
              parse_phase_next = tche_pkg::PH_IP4;
              section_start_next = pos_inc;
              header_length_next = '0;
            end else if (ext_word == tche_pkg::TYPE_IPV6) begin
              ip_version_seen_next = 2'd2;
              parse_phase_next = tche_pkg::PH_IP6;
              section_start_next = pos_inc;
              header_length_next = '0;
            end else begin
              frame_status_next = tche_pkg::ST_ETHERTYPE;
              parse_phase_next = tche_pkg::PH_STOP;
            end
          end
        end
        tche_pkg::PH_IP4: begin
          if (off == 16'd0) begin
            header_length_next = {2'b00, in_byte[3:0], 2'b00};
            if (in_byte[3:0] < 4'd5) begin
              frame_status_next = tche_pkg::ST_IP_HL;
              parse_phase_next = tche_pkg::PH_STOP;
            end
          end else if (off == 16'd9 && in_byte != tche_pkg::PROTO_TCP) begin
            frame_status_next = tche_pkg::ST_NOT_TCP;
            parse_phase_next = tche_pkg::PH_STOP;
          end else if (off + 16'd1 == {8'd0, header_length}) begin
            parse_phase_next = tche_pkg::PH_TCP;
            section_start_next = pos_inc;
            header_length_next = '0;
          end
        end
        tche_pkg::PH_IP6: begin
          if (off == 16'd0 && in_byte[7:4] != 4'd6) frame_status_next = tche_pkg::ST_V6_VER;
          if (off == 16'd6 && in_byte != tche_pkg::PROTO_TCP &&
              frame_status == tche_pkg::ST_OK)
            frame_status_next = tche_pkg::ST_NOT_TCP;
          if (off == 16'd39) begin
            parse_phase_next = tche_pkg::PH_TCP;
            section_start_next = pos_inc;
            header_length_next = '0;
          end
        end
        tche_pkg::PH_TCP: begin
          if (off == 16'd12) begin
            header_length_next = {2'b00, in_byte[7:4], 2'b00};
            if (in_byte[7:4] < 4'd5) begin
              frame_status_next = tche_pkg::ST_TCP_HL;
              parse_phase_next = tche_pkg::PH_STOP;
            end
          end else if (off > 16'd12 && off + 16'd1 == {8'd0, header_length}) begin
            parse_phase_next = tche_pkg::PH_TLS;
            section_start_next = pos_inc;
            header_length_next = '0;
          end
        end
        tche_pkg::PH_TLS: begin
          if (off == 16'd0) begin
            if (v6 && in_byte != tche_pkg::REC_HANDSHAKE) begin
              frame_status_next = tche_pkg::ST_NOT_HELLO;
              parse_phase_next = tche_pkg::PH_STOP;
            end
          end else if (off == 16'd1) begin
            byte_accumulator_next = {in_byte, 8'd0};
            if (v6 && in_byte != 8'd3) begin
              frame_status_next = tche_pkg::ST_NOT_HELLO;
              parse_phase_next = tche_pkg::PH_STOP;
            end
          end else if (off == 16'd2) begin
            if (frame_status == tche_pkg::ST_OK) begin
              step.elem_valid = 1'b1;
              step.elem.kind = tche_pkg::K_REC;
              step.elem.value = ext_word;
            end
          end else if (off == 16'd5) begin
            if (v6 && in_byte != 8'd1) begin
              frame_status_next = tche_pkg::ST_NOT_HELLO;
              parse_phase_next = tche_pkg::PH_STOP;
            end
          end else if (off == 16'(tche_pkg::HELLO_VERSION_OFFSET)) begin
            byte_accumulator_next = {in_byte, 8'd0};
            if (v6) begin
              if (in_byte != 8'd3) begin
                frame_status_next = tche_pkg::ST_NOT_HELLO;
                parse_phase_next = tche_pkg::PH_STOP;
              end else if (frame_status != tche_pkg::ST_OK) begin
                parse_phase_next = tche_pkg::PH_STOP;
              end
            end
          end else if (off == 16'(tche_pkg::HELLO_VERSION_OFFSET + 1)) begin
            if (ext_word < tche_pkg::HELLO_MIN || ext_word > tche_pkg::HELLO_MAX) begin
              frame_status_next = tche_pkg::ST_TLS_VER;
              parse_phase_next = tche_pkg::PH_STOP;
            end else begin
              step.elem_valid = 1'b1;
              step.elem.kind = tche_pkg::K_HELLO;
              step.elem.value = ext_word;
            end
          end else if (off == 16'(tche_pkg::SESSION_LENGTH_OFFSET)) begin
            session_id_length_next = in_byte;
          end else if (off == cs_hi) begin
            byte_accumulator_next = {in_byte, 8'd0};
          end else if (off == cs_hi + 16'd1) begin
            section_remaining_next = ext_word;
            header_length_next = 8'd2;
            parse_phase_next = (ext_word != 16'd0) ? tche_pkg::PH_CIPH : tche_pkg::PH_COMP_LEN;
          end
        end
        tche_pkg::PH_CIPH: begin
          section_remaining_next = sec_dec;
          if (header_length == 8'd3) begin
            step.elem_valid = 1'b1;
            step.elem.kind = tche_pkg::K_CIPHER;
            step.elem.value = {session_id_length, in_byte};
            header_length_next = 8'd2;
          end else if (sec_dec == 16'd0) begin
            step.elem_valid = 1'b1;
            step.elem.kind = tche_pkg::K_CIPHER;
            step.elem.value = {8'd0, in_byte};
          end else begin
            session_id_length_next = in_byte;
            header_length_next = 8'd3;
          end
          if (sec_dec == 16'd0) parse_phase_next = tche_pkg::PH_COMP_LEN;
        end
        tche_pkg::PH_COMP_LEN: begin
          section_remaining_next = {8'd0, in_byte};
          parse_phase_next = (in_byte != 8'd0) ? tche_pkg::PH_COMP : tche_pkg::PH_XLEN_HI;
        end
        tche_pkg::PH_COMP: begin
          step.elem_valid = 1'b1;
          step.elem.kind = tche_pkg::K_COMP;
          step.elem.value = {8'd0, in_byte};
          section_remaining_next = sec_dec;
          if (sec_dec == 16'd0) parse_phase_next = tche_pkg::PH_XLEN_HI;
        end
        tche_pkg::PH_XLEN_HI: begin
          byte_accumulator_next = {in_byte, 8'd0};
          parse_phase_next = tche_pkg::PH_XLEN_LO;
        end
        tche_pkg::PH_XLEN_LO: begin
          extensions_remaining_next = ext_word;
          parse_phase_next = (ext_word != 16'd0) ? tche_pkg::PH_XTYPE_HI : tche_pkg::PH_DONE;
        end
        tche_pkg::PH_XTYPE_HI, tche_pkg::PH_XTYPE_LO, tche_pkg::PH_XBODYLEN_HI,
        tche_pkg::PH_XBODYLEN_LO, tche_pkg::PH_XBODY: begin
          extensions_remaining_next = extensions_remaining - 16'd1;
          case (parse_phase)
            tche_pkg::PH_XTYPE_HI: begin
              byte_accumulator_next = {in_byte, 8'd0};
              parse_phase_next = tche_pkg::PH_XTYPE_LO;
            end
            tche_pkg::PH_XTYPE_LO: begin
              current_ext_type_next = ext_word;
              step.elem_valid = 1'b1;
              step.elem.kind = tche_pkg::K_EXT;
              step.elem.value = ext_word;
              parse_phase_next = tche_pkg::PH_XBODYLEN_HI;
            end
            tche_pkg::PH_XBODYLEN_HI: begin
              byte_accumulator_next = {in_byte, 8'd0};
              parse_phase_next = tche_pkg::PH_XBODYLEN_LO;
            end
            tche_pkg::PH_XBODYLEN_LO: begin
              section_remaining_next = ext_word;
              header_length_next = '0;
              byte_accumulator_next = '0;
              parse_phase_next = (ext_word != 16'd0) ? tche_pkg::PH_XBODY
                                                     : tche_pkg::PH_XTYPE_HI;
            end
            default: begin
              section_remaining_next = sec_dec;
              body_end = list_end || (sec_dec == 16'd0);
              if (current_ext_type == tche_pkg::EXT_CURVES ||
                  current_ext_type == tche_pkg::EXT_SIG_ALG) begin
                if (header_length == 8'd0) begin
                  byte_accumulator_next = {in_byte, 8'd0};
                  header_length_next = 8'd1;
                end else if (header_length == 8'd1) begin
                  byte_accumulator_next = ext_word;
                  header_length_next = 8'd2;
                end else if (byte_accumulator != 16'd0) begin
                  byte_accumulator_next = acc_dec;
                  step.elem.kind = (current_ext_type == tche_pkg::EXT_CURVES)
                                   ? tche_pkg::K_CURVE : tche_pkg::K_SIG;
                  if (header_length == 8'd3) begin
                    step.elem_valid = 1'b1;
                    step.elem.value = {session_id_length, in_byte};
                    header_length_next = 8'd2;
                  end else if (acc_dec == 16'd0 || body_end) begin
                    step.elem_valid = 1'b1;
                    step.elem.value = {8'd0, in_byte};
                  end else begin
                    session_id_length_next = in_byte;
                    header_length_next = 8'd3;
                  end
                end
              end else if (current_ext_type == tche_pkg::EXT_POINT_FMT) begin
                if (header_length == 8'd0) begin
                  byte_accumulator_next = {8'd0, in_byte};
                  header_length_next = 8'd2;
                end else if (byte_accumulator != 16'd0) begin
                  byte_accumulator_next = acc_dec;
                  step.elem_valid = 1'b1;
                  step.elem.kind = tche_pkg::K_POINT;
                  step.elem.value = {8'd0, in_byte};
                end
              end
              if (sec_dec == 16'd0) parse_phase_next = tche_pkg::PH_XTYPE_HI;
            end
          endcase
          if (list_end) parse_phase_next = tche_pkg::PH_DONE;
        end
        default: begin
        end
      endcase
    end
    after_ph_off = byte_position_next - section_start_next;
    if (in_last) begin
      if (parse_phase_next == tche_pkg::PH_STOP) st = frame_status_next;
      else if (parse_phase_next == tche_pkg::PH_XLEN_HI ||
               parse_phase_next == tche_pkg::PH_XLEN_LO ||
               parse_phase_next == tche_pkg::PH_DONE) st = tche_pkg::ST_OK;
      else if (parse_phase_next == tche_pkg::PH_TLS &&
               after_ph_off >= 16'(tche_pkg::HELLO_VERSION_OFFSET + 2))
        st = tche_pkg::ST_SESSION;
      step.sum_valid = 1'b1;
      step.sum.kind = tche_pkg::K_SUMMARY;
      step.sum.status = st;
      step.sum.final_res = 1'b1;
      byte_position_next = '0;
      parse_phase_next = tche_pkg::PH_ETH;
      vlan_tag_count_next = '0;
      section_start_next = '0;
      header_length_next = '0;
      ip_version_seen_next = '0;
      section_remaining_next = '0;
      extensions_remaining_next = '0;
      current_ext_type_next = '0;
      byte_accumulator_next = '0;
      session_id_length_next = '0;
      frame_status_next = '0;
    end
  end
endmodule

FILE: hdl/tche_out_queue.sv
// output queue: holds up to two results per item, four deep, drains one per cycle while out_ready is high
`timescale 1ns / 1ps
module tche_out_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tche_pkg::step_t step,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output tche_pkg::result_t out_res
);
  tche_pkg::result_t slots [4];
  logic [1:0] rd_ptr, wr_ptr;
  logic [2:0] count, count_next;
  logic pop;
  logic [1:0] n_in;

  assign pop = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_res = slots[rd_ptr];
  assign space = (count <= 3'd2);
  assign n_in = push ? (2'(step.elem_valid) + 2'(step.sum_valid)) : 2'd0;
  assign count_next = count + 3'(n_in) - 3'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      rd_ptr <= rd_ptr + 2'(pop);
      wr_ptr <= wr_ptr + n_in;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (step.elem_valid) begin
        slots[wr_ptr] <= step.elem;
        if (step.sum_valid) slots[wr_ptr + 2'd1] <= step.sum;
      end else if (step.sum_valid) begin
        slots[wr_ptr] <= step.sum;
      end
    end
  end
endmodule

FILE: hdl/tls_client_hello_field_extractor.sv
// top level: client hello field extractor
// each result is queued when its byte is accepted and is offered from the queue
// throughput: one byte per cycle unless stalled; an item may give up to two results,
// drained one per cycle; byte input stalls only when the four-entry queue could overflow
// reset: synchronous active-high rst clears the parse state and empties the queue
`timescale 1ns / 1ps
module tls_client_hello_field_extractor #(
  parameter int MAX_VLAN_TAGS = tche_pkg::MAX_VLAN_TAGS,
  parameter int MAX_FRAME_BYTES = tche_pkg::MAX_FRAME_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic s_tlast,         // last_byte
  output logic m_tvalid,
  input  logic m_tready,
  output logic [23:0] m_tdata,  // value[15:0], status[19:16], zero fill
  output logic [3:0] m_tuser,   // kind
  output logic m_tlast          // final_res
);
  tche_pkg::step_t step;
  tche_pkg::result_t res;
  logic acc;

  assign acc = s_tvalid && s_tready;

  tche_parser #(.MAX_VLAN_TAGS(MAX_VLAN_TAGS), .MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_parser (
    .clk(clk), .rst(rst), .in_valid(acc), .in_byte(s_tdata), .in_last(s_tlast), .step(step)
  );

  tche_out_queue u_queue (
    .clk(clk), .rst(rst), .push(acc), .step(step), .space(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tdata = {4'd0, res.status, res.value};
  assign m_tuser = res.kind;
  assign m_tlast = res.final_res;
endmodule

FILE: hdl/tche_checker.sv
// checker: port-level assertions, bound to the top level
`timescale 1ns / 1ps
module tche_checker (
  input logic clk,
  input logic rst,
  input logic m_tvalid,
  input logic m_tready,
  input logic [23:0] m_tdata,
  input logic [3:0] m_tuser,
  input logic m_tlast
);
  a_last_is_summary: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == tche_pkg::K_SUMMARY) else $error("final not summary");
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == tche_pkg::K_SUMMARY |-> m_tlast && m_tdata[15:0] == 16'd0)
    else $error("bad summary");
  a_elem_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[19:16] == tche_pkg::ST_OK) else $error("element status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("stall dropped");
  a_idle_reset: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("valid after reset");
endmodule

bind tls_client_hello_field_extractor tche_checker u_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
